// File: rtl/lsrc_pkg.sv
`timescale 1ns / 1ps
package lsrc_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CFG_W = 5;
    localparam int KEY_W = 64;
    localparam int TICK_W = 64;
    localparam int BYTES_W = 40;
    localparam int VER_W = 32;
    localparam int SUM_W = 44;
    localparam int STAT_W = 32;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);

    typedef struct packed {
        logic [KEY_W-1:0]   tag_key;
        logic               tag_known;
        logic [BYTES_W-1:0] tensor_bytes;
    } req_t;

    typedef struct packed {
        logic [3:0]        slot_index;
        logic [VER_W-1:0]  slot_version;
        logic              was_hit;
        logic              unknown_tag;
        logic              evicted_payload;
        logic [SUM_W-1:0]  resident_total;
        logic [STAT_W-1:0] hit_total;
        logic [STAT_W-1:0] miss_total;
    } rsp_t;

    // scan record handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   hit_idx;
        logic [VER_W-1:0]   hit_ver;
        logic               has_min;
        logic [TICK_W-1:0]  min_use;
        logic [IDX_W-1:0]   vic_idx;
        logic               vic_occ;
        logic [BYTES_W-1:0] vic_bytes;
        logic [VER_W-1:0]   vic_ver;
    } scan_rec_t;

    // update broadcast to all cells at commit
    typedef struct packed {
        logic               en;
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
        logic [TICK_W-1:0]  tick;
    } slot_wr_t;

endpackage

// File: rtl/lsrc_cell.sv
`timescale 1ns / 1ps
module lsrc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lsrc_pkg::IDX_W-1:0]    cell_idx,
    input  logic                          active,
    input  logic [lsrc_pkg::KEY_W-1:0]    req_key,
    input  logic                          tok_in,
    input  lsrc_pkg::scan_rec_t           rec_in,
    input  lsrc_pkg::slot_wr_t            wr,
    output logic                          tok_out,
    output lsrc_pkg::scan_rec_t           rec_out
);

    logic [lsrc_pkg::KEY_W-1:0]   key_reg;
    logic                         occ_reg;
    logic [lsrc_pkg::TICK_W-1:0]  use_reg;
    logic [lsrc_pkg::VER_W-1:0]   ver_reg;
    logic [lsrc_pkg::BYTES_W-1:0] bytes_reg;

    logic                tok_reg;
    lsrc_pkg::scan_rec_t rec_reg;
    lsrc_pkg::scan_rec_t rec_next;

    always_comb
    begin
        rec_next = rec_in;
        if (active)
        begin
            // lowest-index match wins
            if (!rec_in.found && occ_reg && (key_reg == req_key))
            begin
                rec_next.found   = 1'b1;
                rec_next.hit_idx = cell_idx;
                rec_next.hit_ver = ver_reg;
            end
            // strict less-than keeps lowest index on ties
            if (!rec_in.has_min || (use_reg < rec_in.min_use))
            begin
                rec_next.has_min   = 1'b1;
                rec_next.min_use   = use_reg;
                rec_next.vic_idx   = cell_idx;
                rec_next.vic_occ   = occ_reg;
                rec_next.vic_bytes = bytes_reg;
                rec_next.vic_ver   = ver_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            occ_reg   <= 1'b0;
            use_reg   <= '0;
            ver_reg   <= '0;
            bytes_reg <= '0;
        end
        else if (wr.en && (wr.idx == cell_idx))
        begin
            use_reg <= wr.tick;
            if (!wr.hit)
            begin
                key_reg   <= wr.key;
                occ_reg   <= 1'b1;
                bytes_reg <= wr.bytes;
                ver_reg   <= ver_reg + 1'b1;
            end
        end
    end

    assign tok_out = tok_reg;
    assign rec_out = rec_reg;

endmodule

// File: rtl/lru_slot_residency_cache_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                       Direction  Transfer
// -------   ----------------------------  ---------  ---------------------------------
// request   start, busy, req              in         start & !busy at rising edge
// result    rsp_valid, rsp                out        one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data in        cfg_valid & cfg_ready (slots_in_use)
//
// Known tag: the accepted request is registered into launch_reg, then a scan token walks the
//   row of slot cells, one cell per cycle, and the update commits as the result lands.
// Unknown tag: result strobe the cycle after accept, no slot or counter touched.
// busy is high from a known-tag accept until its result; cfg_ready = !busy.
// Reset (rst_n, async low) clears every slot, all counters, and sets slots_in_use to 16.
// Results are never stalled: the receiver must take each strobe as it comes.
module lru_slot_residency_cache_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lsrc_pkg::req_t                req,
    output logic                          rsp_valid,
    output lsrc_pkg::rsp_t                rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lsrc_pkg::CFG_W-1:0]    cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;

    logic [lsrc_pkg::CFG_W-1:0]   slots_cfg_reg;
    logic [lsrc_pkg::TICK_W-1:0]  tick_reg;
    logic [lsrc_pkg::SUM_W-1:0]   resident_reg;
    logic [lsrc_pkg::TICK_W-1:0]  streamed_reg;
    logic [lsrc_pkg::STAT_W-1:0]  hit_cnt_reg;
    logic [lsrc_pkg::STAT_W-1:0]  miss_cnt_reg;
    logic [lsrc_pkg::STAT_W-1:0]  evict_cnt_reg;

    logic [lsrc_pkg::KEY_W-1:0]   req_key_reg;
    logic [lsrc_pkg::BYTES_W-1:0] req_bytes_reg;
    logic                         launch_reg;

    logic                         rsp_valid_reg;
    lsrc_pkg::rsp_t               rsp_reg;

    logic                         accept;
    logic                         commit;
    logic [lsrc_pkg::CNT_W-1:0]   n_eff;
    logic [lsrc_pkg::SUM_W-1:0]   resident_new;
    lsrc_pkg::scan_rec_t          fin;
    lsrc_pkg::slot_wr_t           wr;

    logic                         tok_chain [lsrc_pkg::SLOTS+1];
    lsrc_pkg::scan_rec_t          rec_chain [lsrc_pkg::SLOTS+1];

    assign busy      = (state_reg == ST_SCAN);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign commit    = (state_reg == ST_SCAN) && tok_chain[lsrc_pkg::SLOTS];
    assign fin       = rec_chain[lsrc_pkg::SLOTS];

    // zero acts as one slot, anything above the row size as the full row
    always_comb
    begin
        if (slots_cfg_reg == '0)
        begin
            n_eff = lsrc_pkg::CNT_W'(1);
        end
        else if (32'(slots_cfg_reg) > lsrc_pkg::SLOTS)
        begin
            n_eff = lsrc_pkg::CNT_W'(lsrc_pkg::SLOTS);
        end
        else
        begin
            n_eff = lsrc_pkg::CNT_W'(slots_cfg_reg);
        end
    end

    // scan token enters cell 0 with an empty record
    assign tok_chain[0] = launch_reg;
    assign rec_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < lsrc_pkg::SLOTS; gi++)
        begin : g_cell
            lsrc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (lsrc_pkg::IDX_W'(gi)),
                .active   (lsrc_pkg::CNT_W'(gi) < n_eff),
                .req_key  (req_key_reg),
                .tok_in   (tok_chain[gi]),
                .rec_in   (rec_chain[gi]),
                .wr       (wr),
                .tok_out  (tok_chain[gi+1]),
                .rec_out  (rec_chain[gi+1])
            );
        end
    endgenerate

    // victim bytes leave, new bytes enter, modulo 2^44
    assign resident_new = resident_reg
                        - lsrc_pkg::SUM_W'(fin.vic_bytes)
                        + lsrc_pkg::SUM_W'(req_bytes_reg);

    always_comb
    begin
        wr.en    = commit;
        wr.hit   = fin.found;
        wr.idx   = fin.found ? fin.hit_idx : fin.vic_idx;
        wr.key   = req_key_reg;
        wr.bytes = req_bytes_reg;
        wr.tick  = tick_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.tag_known)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slots_cfg_reg <= lsrc_pkg::SLOTS_IN_USE_RST;
            tick_reg      <= '0;
            resident_reg  <= '0;
            streamed_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            launch_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= accept && req.tag_known;
            rsp_valid_reg <= (accept && !req.tag_known) || commit;
            if (cfg_valid && cfg_ready)
            begin
                slots_cfg_reg <= cfg_data;
            end
            if (accept && req.tag_known)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (commit)
            begin
                if (fin.found)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 1'b1;
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                    resident_reg <= resident_new;
                    streamed_reg <= streamed_reg + lsrc_pkg::TICK_W'(req_bytes_reg);
                    if (fin.vic_occ)
                    begin
                        evict_cnt_reg <= evict_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // request payload latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_key_reg   <= req.tag_key;
            req_bytes_reg <= req.tensor_bytes;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && !req.tag_known)
        begin
            rsp_reg.slot_index      <= '0;
            rsp_reg.slot_version    <= '0;
            rsp_reg.was_hit         <= 1'b0;
            rsp_reg.unknown_tag     <= 1'b1;
            rsp_reg.evicted_payload <= 1'b0;
            rsp_reg.resident_total  <= resident_reg;
            rsp_reg.hit_total       <= hit_cnt_reg;
            rsp_reg.miss_total      <= miss_cnt_reg;
        end
        else if (commit)
        begin
            rsp_reg.slot_index  <= 4'(wr.idx);
            rsp_reg.was_hit     <= fin.found;
            rsp_reg.unknown_tag <= 1'b0;
            if (fin.found)
            begin
                rsp_reg.slot_version    <= fin.hit_ver;
                rsp_reg.evicted_payload <= 1'b0;
                rsp_reg.resident_total  <= resident_reg;
                rsp_reg.hit_total       <= hit_cnt_reg + 1'b1;
                rsp_reg.miss_total      <= miss_cnt_reg;
            end
            else
            begin
                rsp_reg.slot_version    <= fin.vic_ver + 1'b1;
                rsp_reg.evicted_payload <= fin.vic_occ;
                rsp_reg.resident_total  <= resident_new;
                rsp_reg.hit_total       <= hit_cnt_reg;
                rsp_reg.miss_total      <= miss_cnt_reg + 1'b1;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
